// ===== sv/rgba_box_filter_3x3_macros.svh =====
// ----------------------------------------------------------------------------
// rgba_box_filter_3x3 assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, idle in reset.
// ----------------------------------------------------------------------------
`ifndef RGBA_BOX_FILTER_3X3_MACROS_SVH
`define RGBA_BOX_FILTER_3X3_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RBF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RBF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg
// Constants, codes and types shared by the RGBA 3x3 box filter modules.
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
  localparam int IROW_W   = HEIGHT_W;
  localparam int POS_W    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int TOT_W    = POS_W + 1;
  localparam int DCNT_W   = $clog2(POS_W + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 13;
  localparam int CFG_DATA_W = 13;

  localparam int CH_W   = 8;
  localparam int NUM_CH = 4;
  localparam int PIX_W  = CH_W * NUM_CH;
  localparam int TAPS   = 9;
  localparam int SUM_W  = 12;

  // floor(x / 9) == (x * 7282) >> 16 for x below 2^12
  localparam int          RECIP_W  = 13;
  localparam int          RECIP_SH = 16;
  localparam logic [12:0] RECIP9   = 13'd7282;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
    logic row_last;
    logic frame_last;
  } pos_flags_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] px;
    logic             emit;
    pos_flags_t       fl;
  } adv_t;

  typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;
  typedef logic [NUM_CH-1:0][CH_W-1:0]  chans_t;
  typedef logic [TAPS-1:0][PIX_W-1:0]   window_t;

endpackage

// ===== sv/rbf_ram.sv =====
// ----------------------------------------------------------------------------
// rbf_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rbf_ram #(
  parameter int DATA_W = 64,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbf_ctrl
// Frame counters, configuration and input handshake. Decides per transaction
// whether the window advances and which edge cases the emitted pixel has.
// A serial divider rebuilds the output row/column after a config write.
// ----------------------------------------------------------------------------
module rbf_ctrl import rbf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [PIX_W-1:0]      px_i,
  input  logic                  s2_en_i,
  output logic                  adv_o,
  output adv_t                  adv_info_o
);

  logic [WIDTH_W-1:0]  w_q, w_d;
  logic [HEIGHT_W-1:0] h_q, h_d;
  logic [TOT_W-1:0]    total_q;
  logic [COL_W-1:0]    in_col_q, in_col_d;
  logic [IROW_W-1:0]   in_row_q, in_row_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    orow_q, orow_d;
  logic [COL_W-1:0]    ocol_q, ocol_d;
  logic                inject_q, inject_d;
  logic                busy_q, busy_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [WIDTH_W-1:0]  drem_q, drem_d;
  logic [POS_W-1:0]    dquo_q, dquo_d;

  logic                is_pix, row_done, flush_ok, take, adv, clr_pre, emit;
  logic [COL_W-1:0]    b_col, b_ocol;
  logic [IROW_W-1:0]   b_row;
  logic [POS_W-1:0]    b_pos, b_orow;
  logic [WIDTH_W-1:0]  col_p1, ocol_p1;
  logic                col_wrap;
  logic [TOT_W-1:0]    pos_p1;
  pos_flags_t          fl;
  logic [WIDTH_W:0]    trial, diff;
  logic                ge;
  logic [WIDTH_W-1:0]  rem_next;
  logic [POS_W-1:0]    quo_next;
  logic [CFG_W_BITS-1:0] wraw;
  logic [CFG_H_BITS-1:0] hraw;

  assign is_pix   = (cmd_i == CMD_PIXEL);
  assign row_done = (in_row_q >= h_q);
  assign flush_ok = row_done && ({1'b0, pos_q} < total_q);

  assign in_ready_o = s2_en_i && !busy_q && !inject_q;
  assign take       = in_valid_i && in_ready_o;
  assign adv        = inject_q ? s2_en_i : (take && (is_pix || flush_ok));
  assign clr_pre    = !inject_q && take && is_pix && row_done;

  assign b_col  = clr_pre ? '0 : in_col_q;
  assign b_row  = clr_pre ? '0 : in_row_q;
  assign b_pos  = clr_pre ? '0 : pos_q;
  assign b_orow = clr_pre ? '0 : orow_q;
  assign b_ocol = clr_pre ? '0 : ocol_q;

  assign emit     = (b_row >= IROW_W'(2)) || ((b_row == IROW_W'(1)) && (b_col != '0));
  assign col_p1   = WIDTH_W'(b_col) + WIDTH_W'(1);
  assign col_wrap = (col_p1 >= w_q);
  assign ocol_p1  = WIDTH_W'(b_ocol) + WIDTH_W'(1);
  assign pos_p1   = TOT_W'(b_pos) + TOT_W'(1);

  assign fl.top        = (b_orow == '0);
  assign fl.bot        = ((TOT_W'(b_orow) + TOT_W'(1)) >= TOT_W'(h_q));
  assign fl.left       = (b_ocol == '0);
  assign fl.right      = (ocol_p1 >= w_q);
  assign fl.row_last   = fl.right;
  assign fl.frame_last = (pos_p1 >= total_q);

  assign adv_o           = adv;
  assign adv_info_o.col  = b_col;
  assign adv_info_o.px   = (!inject_q && is_pix) ? px_i : '0;
  assign adv_info_o.emit = emit;
  assign adv_info_o.fl   = fl;

  // restoring division step: pos / width
  assign trial    = {drem_q, dquo_q[POS_W-1]};
  assign diff     = trial - {1'b0, w_q};
  assign ge       = (trial >= {1'b0, w_q});
  assign rem_next = ge ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
  assign quo_next = {dquo_q[POS_W-2:0], ge};

  assign wraw = cfg_wdata_i[CFG_W_BITS-1:0];
  assign hraw = cfg_wdata_i[CFG_H_BITS-1:0];

  always_comb begin
    w_d      = w_q;
    h_d      = h_q;
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    pos_d    = pos_q;
    orow_d   = orow_q;
    ocol_d   = ocol_q;
    inject_d = inject_q;
    busy_d   = busy_q;
    dcnt_d   = dcnt_q;
    drem_d   = drem_q;
    dquo_d   = dquo_q;

    if (adv) begin
      in_col_d = col_wrap ? '0 : col_p1[COL_W-1:0];
      in_row_d = col_wrap ? b_row + IROW_W'(1) : b_row;
      pos_d    = b_pos;
      orow_d   = b_orow;
      ocol_d   = b_ocol;
      if (emit) begin
        if (fl.frame_last) begin
          in_col_d = '0;
          in_row_d = '0;
          pos_d    = '0;
          orow_d   = '0;
          ocol_d   = '0;
        end else begin
          pos_d = pos_p1[POS_W-1:0];
          if (fl.right) begin
            ocol_d = '0;
            orow_d = b_orow + POS_W'(1);
          end else begin
            ocol_d = ocol_p1[COL_W-1:0];
          end
        end
      end
    end

    // single-row frame: first flush needs a second window step
    if (inject_q && s2_en_i) begin
      inject_d = 1'b0;
    end else if (take && !is_pix && flush_ok && !emit) begin
      inject_d = 1'b1;
    end

    if (busy_q) begin
      drem_d = rem_next;
      dquo_d = quo_next;
      dcnt_d = dcnt_q + DCNT_W'(1);
      if (dcnt_q == DCNT_W'(POS_W - 1)) begin
        busy_d = 1'b0;
        orow_d = quo_next;
        ocol_d = rem_next[COL_W-1:0];
      end
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH: begin
          if (wraw == '0) begin
            w_d = WIDTH_W'(1);
          end else if (32'(wraw) > 32'(MAX_WIDTH)) begin
            w_d = WIDTH_W'(MAX_WIDTH);
          end else begin
            w_d = WIDTH_W'(wraw);
          end
        end
        REG_HEIGHT: begin
          if (hraw == '0) begin
            h_d = HEIGHT_W'(1);
          end else if (32'(hraw) > 32'(MAX_HEIGHT)) begin
            h_d = HEIGHT_W'(MAX_HEIGHT);
          end else begin
            h_d = HEIGHT_W'(hraw);
          end
        end
        default: begin
        end
      endcase
      busy_d = 1'b1;
      dcnt_d = '0;
      drem_d = '0;
      dquo_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= WIDTH_W'(WIDTH_RST);
      h_q      <= HEIGHT_W'(HEIGHT_RST);
      total_q  <= TOT_W'(WIDTH_RST * HEIGHT_RST);
      in_col_q <= '0;
      in_row_q <= '0;
      pos_q    <= '0;
      orow_q   <= '0;
      ocol_q   <= '0;
      inject_q <= 1'b0;
      busy_q   <= 1'b0;
      dcnt_q   <= '0;
      drem_q   <= '0;
      dquo_q   <= '0;
    end else begin
      w_q      <= w_d;
      h_q      <= h_d;
      total_q  <= TOT_W'(h_q) * TOT_W'(w_q);
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      pos_q    <= pos_d;
      orow_q   <= orow_d;
      ocol_q   <= ocol_d;
      inject_q <= inject_d;
      busy_q   <= busy_d;
      dcnt_q   <= dcnt_d;
      drem_q   <= drem_d;
      dquo_q   <= dquo_d;
    end
  end

endmodule

// ===== sv/rbf_dpath.sv =====
// ----------------------------------------------------------------------------
// rbf_dpath
// Line store read-modify-write with same-address forwarding, 3x3 window,
// edge-replicated channel sums, divide by nine and the output register.
// ----------------------------------------------------------------------------
module rbf_dpath import rbf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  adv_t               adv_info_i,
  input  logic [2*PIX_W-1:0] ram_rdata_i,
  output logic               ram_we_o,
  output logic [COL_W-1:0]   ram_waddr_o,
  output logic [2*PIX_W-1:0] ram_wdata_o,
  output logic               s2_en_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output chans_t             out_ch_o,
  output logic               row_last_o,
  output logic               frame_last_o
);

  localparam int PROD_W = SUM_W + RECIP_W;

  logic             v2_q, v3_q, v4_q, v5_q;
  adv_t             s2_q;
  logic             fwd_q;
  logic [PIX_W-1:0] fwd_near_q, fwd_far_q;
  window_t          win_q;
  pos_flags_t       fl3_q, fl4_q, fl5_q;
  sums_t            sum4_q, sum_d;
  chans_t           out_q, quo_d;

  logic             en2, en3, en4, en5, done2;
  logic [PIX_W-1:0] near_old, far_old;
  logic [PROD_W-1:0] prod [NUM_CH];

  assign en5   = !v5_q || out_ready_i;
  assign en4   = !v4_q || en5;
  assign en3   = !v3_q || en4;
  assign en2   = !v2_q || en3;
  assign done2 = v2_q && en3;

  assign near_old = fwd_q ? fwd_near_q : ram_rdata_i[PIX_W-1:0];
  assign far_old  = fwd_q ? fwd_far_q  : ram_rdata_i[2*PIX_W-1:PIX_W];

  assign ram_we_o    = done2;
  assign ram_waddr_o = s2_q.col;
  assign ram_wdata_o = {near_old, s2_q.px};
  assign s2_en_o     = en2;

  always_comb begin
    int rr;
    int cc;
    sum_d = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int ri = 0; ri < 3; ri++) begin
        for (int ci = 0; ci < 3; ci++) begin
          rr = ri;
          cc = ci;
          if (ri == 0 && fl3_q.top) rr = 1;
          if (ri == 2 && fl3_q.bot) rr = 1;
          if (ci == 0 && fl3_q.left) cc = 1;
          if (ci == 2 && fl3_q.right) cc = 1;
          sum_d[ch] = sum_d[ch] + SUM_W'(win_q[rr*3 + cc][ch*CH_W +: CH_W]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch]  = PROD_W'(sum4_q[ch]) * PROD_W'(RECIP9);
      quo_d[ch] = prod[ch][RECIP_SH +: CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      fwd_q <= 1'b0;
      win_q <= '0;
    end else begin
      if (en2) begin
        v2_q <= adv_i;
      end
      if (adv_i) begin
        fwd_q <= done2 && (adv_info_i.col == s2_q.col);
      end
      if (done2) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k*3]     <= win_q[k*3 + 1];
          win_q[k*3 + 1] <= win_q[k*3 + 2];
        end
        win_q[2] <= far_old;
        win_q[5] <= near_old;
        win_q[8] <= s2_q.px;
      end
      if (en3) begin
        v3_q <= done2 && s2_q.emit;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_q       <= adv_info_i;
      fwd_near_q <= s2_q.px;
      fwd_far_q  <= near_old;
    end
    if (done2) begin
      fl3_q <= s2_q.fl;
    end
    if (v3_q && en4) begin
      sum4_q <= sum_d;
      fl4_q  <= fl3_q;
    end
    if (v4_q && en5) begin
      out_q <= quo_d;
      fl5_q <= fl4_q;
    end
  end

  assign out_valid_o  = v5_q;
  assign out_ch_o     = out_q;
  assign row_last_o   = fl5_q.row_last;
  assign frame_last_o = fl5_q.frame_last;

endmodule

// ===== sv/rgba_box_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// rgba_box_filter_3x3
// Streaming 3x3 mean filter over RGBA pixels with edge replication.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): one pixel or flush per transaction,
// raster order. Output channel (out_valid_o/out_ready_i): one filtered pixel
// with row/frame end marks. Config port: cfg_we_i writes register cfg_idx_i
// (0 = width, 1 = height) with cfg_wdata_i; the user must write only while
// the block is idle; it does not enforce this. Throughput: one transaction per
// cycle when not stalled. Output pixel p follows input pixel p + width + 1; it
// then passes the line store read, window, sum and divide registers. After the
// last pixel, width + 1 flushes (width in a one-row frame) drain the frame. In
// a one-row frame the first flush holds input off for an inserted window step.
// A config write holds input off while a serial divider re-derives the output
// row and column from the output position. Reset: counters and window clear;
// width 640, height 480; line stores are not cleared. A stalled receiver holds
// the output register; the pipeline keeps filling its free stages and input
// stalls only once all are full.
`include "rgba_box_filter_3x3_macros.svh"

module rgba_box_filter_3x3 import rbf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [CH_W-1:0]       red_in_i,
  input  logic [CH_W-1:0]       green_in_i,
  input  logic [CH_W-1:0]       blue_in_i,
  input  logic [CH_W-1:0]       alpha_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CH_W-1:0]       red_out_o,
  output logic [CH_W-1:0]       green_out_o,
  output logic [CH_W-1:0]       blue_out_o,
  output logic [CH_W-1:0]       alpha_out_o,
  output logic                  row_last_o,
  output logic                  frame_last_o
);

  logic               adv;
  adv_t               adv_info;
  logic               s2_en;
  logic [2*PIX_W-1:0] ram_rdata, ram_wdata;
  logic               ram_we;
  logic [COL_W-1:0]   ram_waddr;
  chans_t             out_ch;

  rbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .px_i        ({alpha_in_i, blue_in_i, green_in_i, red_in_i}),
    .s2_en_i     (s2_en),
    .adv_o       (adv),
    .adv_info_o  (adv_info)
  );

  rbf_ram #(
    .DATA_W (2 * PIX_W),
    .ADDR_W (COL_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv),
    .raddr_i (adv_info.col),
    .rdata_o (ram_rdata)
  );

  rbf_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .adv_info_i   (adv_info),
    .ram_rdata_i  (ram_rdata),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .s2_en_o      (s2_en),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_ch_o     (out_ch),
    .row_last_o   (row_last_o),
    .frame_last_o (frame_last_o)
  );

  assign red_out_o   = out_ch[0];
  assign green_out_o = out_ch[1];
  assign blue_out_o  = out_ch[2];
  assign alpha_out_o = out_ch[3];

  `RBF_ASSERT_IMP(a_frame_ends_row, out_valid_o && frame_last_o, row_last_o, "frame end off row end")
  `RBF_ASSERT_NXT(a_cfg_blocks_input, cfg_we_i, !in_ready_o, "input taken during reconfiguration")

endmodule
